// ===== hw/rtl/cross_entropy_loss_mean_top_assert.svh =====
// assertion macros for the cross entropy loss block
// used by cross_entropy_loss_mean_top only
`ifndef CROSS_ENTROPY_LOSS_MEAN_TOP_ASSERT_SVH
`define CROSS_ENTROPY_LOSS_MEAN_TOP_ASSERT_SVH
// implication checked on every clock, off during reset
`define CEL_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define CEL_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/cel_pkg.sv =====
// shared types and constants for the cross entropy loss block
// no dependencies
package cel_pkg;
    localparam logic [27:0] CLIP_LOW_RESET  = 28'd60;
    localparam logic [27:0] CLIP_HIGH_RESET = 28'd71868951;
    localparam logic [27:0] LN2_Q28         = 28'd186065280;
    localparam logic signed [19:0] LOSS_MAX = 20'sd524287;
    localparam logic signed [19:0] LOSS_MIN = -20'sd524288;
    localparam logic REG_CLIP_LOW  = 1'b0;
    localparam logic REG_CLIP_HIGH = 1'b1;

    // one finished sample passed from front to back
    typedef struct packed {
        logic [27:0] value;
        logic        found;
        logic        end_batch;
    } cel_job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } cel_state_t;
endpackage

// ===== hw/rtl/cel_front.sv =====
// front part: selects the target element of each sample and clamps it
// depends on cel_pkg
module cel_front #(
    parameter int MAX_CLASSES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [27:0]       probability,
    input  logic [9:0]        class_index,
    input  logic [9:0]        target_class,
    input  logic              end_sample,
    input  logic              end_batch,
    input  logic [27:0]       clip_low,
    input  logic [27:0]       clip_high,
    output logic              job_valid,
    output cel_pkg::cel_job_t job
);
    logic [27:0] sel_reg;
    logic        found_reg;
    logic        match;
    logic [27:0] sel_now;
    logic        found_now;
    logic [27:0] clamped;

    // classes at or beyond the class limit never match
    always_comb
    begin
        match     = (class_index == target_class) && (int'(class_index) < MAX_CLASSES);
        sel_now   = match ? probability : sel_reg;
        found_now = match | found_reg;
        clamped   = (sel_now < clip_high) ? sel_now : clip_high;
        if (clamped < clip_low)
        begin
            clamped = clip_low;
        end
    end

    assign job_valid     = in_valid && (end_sample || end_batch);
    assign job.value     = clamped;
    assign job.found     = found_now;
    assign job.end_batch = end_batch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            found_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            if (end_sample || end_batch)
            begin
                sel_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                sel_reg   <= sel_now;
                found_reg <= found_now;
            end
        end
    end
endmodule

// ===== hw/rtl/cel_fifo.sv =====
// short job queue between front and back
// depends on cel_pkg
module cel_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  cel_pkg::cel_job_t wr_data,
    input  logic              rd_en,
    output cel_pkg::cel_job_t rd_data,
    output logic              empty,
    output logic              full
);
    cel_pkg::cel_job_t mem_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;

    assign empty   = (cnt_reg == 3'd0);
    assign full    = (cnt_reg == 3'd4);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};
        end
    end
endmodule

// ===== hw/rtl/cel_back.sv =====
// back part: logarithm by squaring, ln2 scaling, accumulation, mean division
// depends on cel_pkg
module cel_back #(
    parameter int MAX_BATCH = 65536,
    parameter int CNT_W     = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  cel_pkg::cel_job_t job,
    output logic              job_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [19:0]       sample_loss,
    output logic              target_missing,
    output logic [19:0]       batch_mean,
    output logic              mean_valid
);
    localparam int SUM_W = CNT_W + 21;

    cel_pkg::cel_state_t st_reg, st_next;
    logic [32:0] m_reg;
    logic [29:0] frac_reg;
    logic [4:0]  it_reg;
    logic signed [5:0] e_reg;
    logic        zero_reg, found_reg, eb_reg;
    logic signed [19:0] loss_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] rem_reg, quo_reg;
    logic [6:0]  dstep_reg;
    logic        dneg_reg;
    logic signed [19:0] mean_reg;
    logic        meanv_reg;

    logic [4:0]  lead;
    logic [63:0] sq;
    logic [32:0] sqt;
    logic signed [36:0] lg;
    logic signed [66:0] prod;
    logic [66:0] mag;
    logic [66:0] rnd;
    logic signed [19:0] loss_c;
    logic [SUM_W-1:0] absum;
    logic [SUM_W:0] trial;
    logic signed [SUM_W:0] qs;

    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < 28; i++)
        begin
            if (job.value[i])
            begin
                lead = 5'(i);
            end
        end
        sq   = {31'd0, m_reg} * {31'd0, m_reg};
        sqt  = 33'(sq >> 31);
        lg   = 37'(e_reg - 6'sd16) * 37'sd1073741824 + $signed({7'd0, frac_reg});
        prod = -(67'(lg) * $signed({39'd0, cel_pkg::LN2_Q28}));
        mag  = prod[66] ? 67'(-prod) : prod;
        rnd  = (mag + (67'd1 << 41)) >> 42;
        if (zero_reg)
        begin
            loss_c = cel_pkg::LOSS_MAX;
        end
        else if (!prod[66])
        begin
            loss_c = (rnd > 67'd524287) ? cel_pkg::LOSS_MAX : 20'(rnd);
        end
        else
        begin
            loss_c = (rnd > 67'd524288) ? cel_pkg::LOSS_MIN : 20'(-rnd);
        end
        absum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        trial = {rem_reg, quo_reg[SUM_W-1]} - {1'b0, {(SUM_W-CNT_W){1'b0}}, cnt_reg};
        qs    = dneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    end

    // state sequencing
    always_comb
    begin
        st_next  = st_reg;
        job_take = 1'b0;
        unique case (st_reg)
            cel_pkg::ST_IDLE:
                if (job_valid)
                begin
                    job_take = 1'b1;
                    st_next  = job.found ? cel_pkg::ST_LOG : cel_pkg::ST_MUL;
                end
            cel_pkg::ST_LOG:
                if (it_reg == 5'd29) st_next = cel_pkg::ST_MUL;
            cel_pkg::ST_MUL:
                st_next = eb_reg ? cel_pkg::ST_DIV : cel_pkg::ST_OUT;
            cel_pkg::ST_DIV:
                if (cnt_reg == '0 || dstep_reg == 7'(SUM_W + 1)) st_next = cel_pkg::ST_OUT;
            cel_pkg::ST_OUT:
                if (out_ready) st_next = cel_pkg::ST_IDLE;
            default:
                st_next = cel_pkg::ST_IDLE;
        endcase
    end

    assign out_valid      = (st_reg == cel_pkg::ST_OUT);
    assign sample_loss    = loss_reg;
    assign target_missing = !found_reg;
    assign batch_mean     = meanv_reg ? mean_reg : 20'sd0;
    assign mean_valid     = meanv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= cel_pkg::ST_IDLE;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == cel_pkg::ST_MUL && found_reg && cnt_reg < CNT_W'(MAX_BATCH))
            begin
                sum_reg <= sum_reg + SUM_W'(loss_c);
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (st_reg == cel_pkg::ST_OUT && out_ready && meanv_reg)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            cel_pkg::ST_IDLE:
            begin
                m_reg     <= 33'({5'd0, job.value} << (5'd31 - lead));
                e_reg     <= $signed({1'b0, lead});
                zero_reg  <= (job.value == '0);
                found_reg <= job.found;
                eb_reg    <= job.end_batch;
                frac_reg  <= '0;
                it_reg    <= '0;
            end
            cel_pkg::ST_LOG:
            begin
                it_reg <= it_reg + 5'd1;
                if (sqt[32])
                begin
                    frac_reg[5'd29 - it_reg] <= 1'b1;
                    m_reg <= sqt >> 1;
                end
                else
                begin
                    m_reg <= sqt;
                end
            end
            cel_pkg::ST_MUL:
            begin
                loss_reg  <= found_reg ? loss_c : 20'sd0;
                meanv_reg <= eb_reg;
                dstep_reg <= '0;
                rem_reg   <= '0;
            end
            cel_pkg::ST_DIV:
            begin
                if (dstep_reg == 7'd0)
                begin
                    // bias by half the count, then restoring division
                    dneg_reg <= sum_reg[SUM_W-1];
                    quo_reg  <= absum + SUM_W'(cnt_reg >> 1);
                    dstep_reg <= 7'd1;
                end
                else if (dstep_reg <= 7'(SUM_W))
                begin
                    dstep_reg <= dstep_reg + 7'd1;
                    if (!trial[SUM_W])
                    begin
                        rem_reg <= trial[SUM_W-1:0];
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                end
                if (cnt_reg == '0)
                begin
                    mean_reg <= 20'sd0;
                end
                else if (dstep_reg == 7'(SUM_W + 1))
                begin
                    if (qs > $signed({{(SUM_W-19){1'b0}}, 20'd524287}))
                        mean_reg <= cel_pkg::LOSS_MAX;
                    else if (qs < -$signed({{(SUM_W-19){1'b0}}, 20'd524288}))
                        mean_reg <= cel_pkg::LOSS_MIN;
                    else
                        mean_reg <= 20'(qs);
                end
            end
            cel_pkg::ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== hw/rtl/cross_entropy_loss_mean_top.sv =====
// flow: a job is taken from the queue in idle, then runs the logarithm by squaring
// (found samples only), scaling and output; a batch end adds the mean division
// throughput: one request per cycle while the four-entry job queue has room;
// the back end takes a new sample only after the last one has been output
// reset: asynchronous active low; clears clamps to defaults and the control and sum registers
module cross_entropy_loss_mean_top #(
    parameter int MAX_CLASSES = 1024,
    parameter int MAX_BATCH   = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // probability[27:0], class_index[37:28], target_class[47:38]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_in_sample
    input  logic        s_axis_tuser,   // last_in_batch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_loss[19:0], batch_mean[39:20]
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,   // mean_valid
    output logic        m_axis_tuser,   // target_missing
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [27:0] cfg_data
);
    localparam int CNT_W = $clog2(MAX_BATCH + 1);

    logic [27:0] clip_low_reg, clip_high_reg;
    logic job_valid, full, empty, take;
    cel_pkg::cel_job_t job_in, job_out;
    logic [19:0] loss, mean;

    // clamp registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_low_reg  <= cel_pkg::CLIP_LOW_RESET;
            clip_high_reg <= cel_pkg::CLIP_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == cel_pkg::REG_CLIP_LOW)
                clip_low_reg <= cfg_data;
            else
                clip_high_reg <= cfg_data;
        end
    end

    // stall input only while the job queue is full
    assign s_axis_tready = !full;

    cel_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid && s_axis_tready),
        .probability(s_axis_tdata[27:0]),
        .class_index(s_axis_tdata[37:28]),
        .target_class(s_axis_tdata[47:38]),
        .end_sample(s_axis_tlast), .end_batch(s_axis_tuser),
        .clip_low(clip_low_reg), .clip_high(clip_high_reg),
        .job_valid(job_valid), .job(job_in)
    );

    cel_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_en(job_valid), .wr_data(job_in),
        .rd_en(take), .rd_data(job_out),
        .empty(empty), .full(full)
    );

    cel_back #(.MAX_BATCH(MAX_BATCH), .CNT_W(CNT_W)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(!empty), .job(job_out), .job_take(take),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .sample_loss(loss), .target_missing(m_axis_tuser),
        .batch_mean(mean), .mean_valid(m_axis_tlast)
    );

    assign m_axis_tdata = {mean, loss};

`include "cross_entropy_loss_mean_top_assert.svh"
    // queue never overflows or underflows
    `CEL_ASSERT_IMP(a_no_ovf, clk, rst_n, full, !job_valid)
    `CEL_ASSERT_IMP(a_no_udf, clk, rst_n, take, !empty)
    // mean field is zero unless flagged
    `CEL_ASSERT_IMP(a_mean_zero, clk, rst_n, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[39:20] == 20'd0)
endmodule
